@@ src/rtn_pkg.sv @@
// ----------------------------------------------------------------------------
// rtn_pkg: shared types and constants for the ROE to RTN state block
// Angle constants, CORDIC arctangent table, register codes and pipeline types.
// ----------------------------------------------------------------------------
package rtn_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int IDX_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
  localparam int OUTPUT_WIDTH = 48;

  // internal datapath widths
  localparam int ROT_W   = 34;  // CORDIC x, y, z in Q30 with headroom
  localparam int PROD_W  = 36;  // element times cos or sin, Q31
  localparam int DRIFT_W = 40;  // da*u in Q31
  localparam int ELEM_W  = 44;  // combined position / velocity terms
  localparam int MUL_W   = 42;  // scale multiplier (a*1000 or V*1000)
  localparam int HALF_M  = 21;  // split of the scale multiplier
  localparam int PP_W    = ELEM_W + HALF_M + 1;
  localparam int SUM_W   = ELEM_W + MUL_W + 1;
  localparam int POS_SHIFT = 31;
  localparam int VEL_SHIFT = 47;

  localparam logic signed [27:0] TWO_PI_Q24  = 28'sd105414357;
  localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [ROT_W-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [25:0] AXIS_RESET    = 26'd6928000;
  localparam logic [48:0] GM_RESET      = 49'd398600441800000;
  localparam logic [35:0] AXIS_MM_RESET = 36'd6928000000;

  typedef enum logic [2:0] {
    REG_AXIS, REG_GM, REG_DA, REG_DL, REG_EX, REG_EY, REG_IX, REG_IY
  } rtn_reg_t;

  typedef enum logic [1:0] {SC_LOAD, SC_DIV, SC_SQRT, SC_IDLE} rtn_scale_state_t;

  // payload handed from one rotation cell to the next
  typedef struct packed {
    logic                    vld;
    logic                    flip;
    logic signed [31:0]      u;
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } rtn_rot_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [ROT_W-1:0] atan_q30(input logic [IDX_W-1:0] idx);
    int i;
    logic signed [ROT_W-1:0] v;
    i = int'(idx);
    case (i)
      0: v = 34'sd843314857;
      1: v = 34'sd497837829;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      default: begin
        if (i <= 30) v = {{(ROT_W-1){1'b0}}, 1'b1} << (30 - i);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

@@ src/rtn_angle_reduce.sv @@
// ----------------------------------------------------------------------------
// rtn_angle_reduce: angle reduction front end
// Reduces the Q7.24 angle modulo 2*pi, folds it into +-pi/2 and seeds the
// rotation chain. Three register stages.
// ----------------------------------------------------------------------------
module rtn_angle_reduce import rtn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic signed [31:0] u,
  output rtn_rot_t           rot
);

  localparam logic [31:0] C16 = 32'd1686629712;
  localparam logic [31:0] C8  = 32'd843314856;
  localparam logic [31:0] C4  = 32'd421657428;
  localparam logic [31:0] C2  = 32'd210828714;
  localparam logic [31:0] C1  = 32'd105414357;

  logic               s1_vld_r, s2_vld_r, s3_vld_r;
  logic               s1_neg_r, s3_flip_r;
  logic signed [31:0] s1_u_r, s2_u_r, s3_u_r;
  logic [31:0]        s1_mag_r;
  logic signed [27:0] s2_r_r;
  logic signed [ROT_W-1:0] s3_z_r;

  logic [31:0]        mag0, ma, mb, mc, md, me;
  logic signed [27:0] r2, r3;
  logic               flip3;

  // magnitude, then subtract 16C and 8C
  always_comb begin
    mag0 = u[31] ? (32'd0 - u) : u;
    ma   = (mag0 >= C16) ? (mag0 - C16) : mag0;
    mb   = (ma >= C8) ? (ma - C8) : ma;
  end

  // subtract 4C, 2C, C and restore the sign of the dividend
  always_comb begin
    mc = (s1_mag_r >= C4) ? (s1_mag_r - C4) : s1_mag_r;
    md = (mc >= C2) ? (mc - C2) : mc;
    me = (md >= C1) ? (md - C1) : md;
    r2 = s1_neg_r ? (28'sd0 - $signed(me[27:0])) : $signed(me[27:0]);
  end

  // wrap into +-pi, fold into +-pi/2
  always_comb begin
    r3    = s2_r_r;
    flip3 = 1'b0;
    if (r3 > PI_Q24) r3 = r3 - TWO_PI_Q24;
    if (r3 < -PI_Q24) r3 = r3 + TWO_PI_Q24;
    if (r3 > HALF_PI_Q24) begin
      r3    = r3 - PI_Q24;
      flip3 = 1'b1;
    end else if (r3 < -HALF_PI_Q24) begin
      r3    = r3 + PI_Q24;
      flip3 = 1'b1;
    end
  end

  // control stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_r  <= u[31];
      s1_u_r    <= u;
      s1_mag_r  <= mb;
      s2_u_r    <= s1_u_r;
      s2_r_r    <= r2;
      s3_u_r    <= s2_u_r;
      s3_flip_r <= flip3;
      s3_z_r    <= ROT_W'(r3) <<< 6;
    end
  end

  assign rot.vld  = s3_vld_r;
  assign rot.flip = s3_flip_r;
  assign rot.u    = s3_u_r;
  assign rot.x    = GAIN_Q30;
  assign rot.y    = '0;
  assign rot.z    = s3_z_r;

endmodule

@@ src/rtn_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// rtn_cordic_cell: one rotation-mode CORDIC micro-rotation
// Holds x, y, z of one item and hands them to the next cell each cycle that adv is high.
// ----------------------------------------------------------------------------
module rtn_cordic_cell import rtn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [IDX_W-1:0] stage_idx,
  input  rtn_rot_t         din,
  output rtn_rot_t         dout
);

  rtn_rot_t dout_r, dout_nxt;
  logic signed [ROT_W-1:0] dx, dy, at;

  // rotate toward zero residual angle
  always_comb begin
    dx       = din.y >>> stage_idx;
    dy       = din.x >>> stage_idx;
    at       = atan_q30(stage_idx);
    dout_nxt = din;
    if (!din.z[ROT_W-1]) begin
      dout_nxt.x = din.x - dx;
      dout_nxt.y = din.y + dy;
      dout_nxt.z = din.z - at;
    end else begin
      dout_nxt.x = din.x + dx;
      dout_nxt.y = din.y - dy;
      dout_nxt.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.vld <= 1'b0;
    end else if (adv) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

@@ src/rtn_scale_lane.sv @@
// ----------------------------------------------------------------------------
// rtn_scale_lane: scaling and saturation of one output component
// Multiplies a term by a*1000 or V*1000 in two partial products, sums them,
// shifts and clips to the output width. Three register stages.
// ----------------------------------------------------------------------------
module rtn_scale_lane import rtn_pkg::*; (
  input  logic                     clk,
  input  logic                     adv,
  input  logic                     is_vel,
  input  logic signed [ELEM_W-1:0] elem,
  input  logic [MUL_W-1:0]         mult,
  output logic signed [OUTPUT_WIDTH-1:0] result,
  output logic                     sat
);

  localparam logic signed [SUM_W-1:0] OUT_MAX =
    (SUM_W'(1) <<< (OUTPUT_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -(SUM_W'(1) <<< (OUTPUT_WIDTH - 1));

  logic signed [PP_W-1:0]  lo_r, hi_r, lo_nxt, hi_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt, shifted;
  logic signed [OUTPUT_WIDTH-1:0] result_r, result_nxt;
  logic sat_r, sat_nxt;

  // partial products against the low and high halves of the multiplier
  always_comb begin
    lo_nxt = PP_W'(elem) * PP_W'($signed({1'b0, mult[HALF_M-1:0]}));
    hi_nxt = PP_W'(elem) * PP_W'($signed({1'b0, mult[MUL_W-1:HALF_M]}));
    sum_nxt = SUM_W'(lo_r) + (SUM_W'(hi_r) <<< HALF_M);
  end

  // floor shift and clip
  always_comb begin
    shifted = is_vel ? (sum_r >>> VEL_SHIFT) : (sum_r >>> POS_SHIFT);
    sat_nxt = (shifted > OUT_MAX) || (shifted < OUT_MIN);
    if (shifted > OUT_MAX) result_nxt = OUT_MAX[OUTPUT_WIDTH-1:0];
    else if (shifted < OUT_MIN) result_nxt = OUT_MIN[OUTPUT_WIDTH-1:0];
    else result_nxt = shifted[OUTPUT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      sum_r    <= sum_nxt;
      result_r <= result_nxt;
      sat_r    <= sat_nxt;
    end
  end

  assign result = result_r;
  assign sat    = sat_r;

endmodule

@@ src/rtn_scale_unit.sv @@
// ----------------------------------------------------------------------------
// rtn_scale_unit: velocity scale sequencer
// Computes floor(sqrt(mu*2^32/a)) with a bit-serial divider followed by a
// bit-pair square root (all ones on overflow or a zero axis), and presents it times 1000.
// ----------------------------------------------------------------------------
module rtn_scale_unit import rtn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [25:0] axis,
  input  logic [48:0] gm,
  output logic        ready,
  output logic [MUL_W-1:0] vm
);

  rtn_scale_state_t state_r, state_nxt;
  logic [6:0]  cnt_r;
  logic [80:0] dvd_r;
  logic [26:0] rem_r, rem_sh;
  logic [63:0] q_r, res_r, bit_r, trial, res_nxt;
  logic        over_r, ge, take;
  logic [31:0] scale_r;
  logic [MUL_W-1:0] vm_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SC_LOAD: state_nxt = SC_DIV;
      SC_DIV:  if (cnt_r == 7'd0) state_nxt = SC_SQRT;
      SC_SQRT: if (cnt_r == 7'd0) state_nxt = SC_IDLE;
      SC_IDLE: if (start) state_nxt = SC_LOAD;
      default: state_nxt = SC_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    ready = (state_r == SC_IDLE);
  end

  // datapath step terms
  always_comb begin
    rem_sh  = {rem_r[25:0], dvd_r[80]};
    ge      = (rem_sh >= {1'b0, axis});
    trial   = res_r + bit_r;
    take    = (q_r >= trial);
    res_nxt = take ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= SC_LOAD;
    else state_r <= state_nxt;
  end

  // divide, then take the root
  always_ff @(posedge clk) begin
    case (state_r)
      SC_LOAD: begin
        dvd_r  <= {gm, 32'd0};
        rem_r  <= '0;
        q_r    <= '0;
        over_r <= (axis == 26'd0);
        cnt_r  <= 7'd80;
      end
      SC_DIV: begin
        rem_r <= ge ? (rem_sh - {1'b0, axis}) : rem_sh;
        q_r   <= {q_r[62:0], ge};
        if (ge && (cnt_r >= 7'd64)) over_r <= 1'b1;
        dvd_r <= dvd_r << 1;
        if (cnt_r == 7'd0) begin
          res_r <= '0;
          bit_r <= 64'd1 << 62;
          cnt_r <= 7'd31;
        end else begin
          cnt_r <= cnt_r - 7'd1;
        end
      end
      SC_SQRT: begin
        if (take) q_r <= q_r - trial;
        res_r <= res_nxt;
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd0) scale_r <= over_r ? 32'hFFFF_FFFF : res_nxt[31:0];
      end
      default: ;
    endcase
  end

  // hold the scale times 1000
  always_ff @(posedge clk) begin
    vm_r <= MUL_W'(scale_r) * MUL_W'(1000);
  end

  assign vm = vm_r;

endmodule

@@ src/rtn_map.sv @@
// ----------------------------------------------------------------------------
// rtn_map: linear circular-orbit map
// Forms the element products with cos and sin, combines them into the six
// RTN terms and scales each in its own lane.
// ----------------------------------------------------------------------------
module rtn_map import rtn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  rtn_rot_t           rot,
  input  logic signed [31:0] da,
  input  logic signed [31:0] dl,
  input  logic signed [31:0] ex,
  input  logic signed [31:0] ey,
  input  logic signed [31:0] ix,
  input  logic signed [31:0] iy,
  input  logic [35:0]        am,
  input  logic [MUL_W-1:0]   vm,
  output logic               out_vld,
  output logic signed [OUTPUT_WIDTH-1:0] res [6],
  output logic               sat
);

  function automatic logic signed [PROD_W-1:0] prod30(
    input logic signed [31:0] d, input logic signed [ROT_W-1:0] t);
    logic signed [65:0] p;
    p = 66'(d) * 66'(t);
    return PROD_W'(p >>> 30);
  endfunction

  logic signed [ROT_W-1:0] c, s;
  logic signed [PROD_W-1:0] exc_r, eys_r, exs_r, eyc_r, ixs_r, iyc_r, ixc_r, iys_r;
  logic signed [DRIFT_W-1:0] drift_r;
  logic signed [63:0] drift_full;
  logic signed [ELEM_W-1:0] ecs, exy, term [6], term_r [6];
  logic [4:0] vld_r;
  logic [5:0] lane_sat;

  // signs restored after the fold
  always_comb begin
    c = rot.flip ? -rot.x : rot.x;
    s = rot.flip ? -rot.y : rot.y;
    drift_full = 64'(da) * 64'(rot.u);
  end

  // element products
  always_ff @(posedge clk) begin
    if (adv) begin
      exc_r   <= prod30(ex, c);
      eys_r   <= prod30(ey, s);
      exs_r   <= prod30(ex, s);
      eyc_r   <= prod30(ey, c);
      ixs_r   <= prod30(ix, s);
      iyc_r   <= prod30(iy, c);
      ixc_r   <= prod30(ix, c);
      iys_r   <= prod30(iy, s);
      drift_r <= DRIFT_W'(drift_full >>> 24);
    end
  end

  // combine into radial, along-track and normal terms
  always_comb begin
    ecs = ELEM_W'(exc_r) + ELEM_W'(eys_r);
    exy = ELEM_W'(exs_r) - ELEM_W'(eyc_r);
    term[0] = ELEM_W'(da) - ecs;
    term[1] = (-(ELEM_W'(drift_r) * 44'sd3) >>> 1) + ELEM_W'(dl) + (exy <<< 1);
    term[2] = ELEM_W'(ixs_r) - ELEM_W'(iyc_r);
    term[3] = exy;
    term[4] = (-(ELEM_W'(da) * 44'sd3) >>> 1) + (ecs <<< 1);
    term[5] = ELEM_W'(ixc_r) + ELEM_W'(iys_r);
  end

  always_ff @(posedge clk) begin
    if (adv) term_r <= term;
  end

  // valid bits alongside the five stages
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[3:0], rot.vld};
  end

  for (genvar g = 0; g < 6; g++) begin : g_lane
    rtn_scale_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .is_vel (g >= 3),
      .elem   (term_r[g]),
      .mult   ((g >= 3) ? vm : MUL_W'(am)),
      .result (res[g]),
      .sat    (lane_sat[g])
    );
  end

  assign out_vld = vld_r[4];
  assign sat     = |lane_sat;

endmodule

@@ src/relative_elements_to_rtn_state.sv @@
// ----------------------------------------------------------------------------
// relative_elements_to_rtn_state: relative orbital elements to RTN state
// Maps an argument of latitude through the quasi-nonsingular ROE linear map.
// ----------------------------------------------------------------------------
// Takes one angle per cycle while in_tready is high and returns one RTN
// state per cycle while out_tready is high; each result passes three
// reduction stages, one rotation cell per CORDIC iteration, two product
// stages and three scaling stages. After reset and after every write of
// the semi-major axis or gravity parameter the velocity scale is
// recomputed by a serial divider and root, during which in_tready and
// cfg_ready stay low. Position is in mm, velocity in mm/s; tuser bit 0
// flags any clipped component.
module relative_elements_to_rtn_state import rtn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,    // [31:0] mean_arg_lat
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,   // pos_radial, pos_along, pos_normal,
                                    // vel_radial, vel_along, vel_normal (48 b each)
  output logic [0:0]   out_tuser,   // [0] saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [48:0]  cfg_data
);

  logic [25:0] axis_r;
  logic [48:0] gm_r;
  logic [35:0] am_r;
  logic signed [31:0] da_r, dl_r, ex_r, ey_r, ix_r, iy_r;
  logic scale_ready, scale_start, cfg_wr, adv, sat;
  logic [MUL_W-1:0] vm;
  rtn_rot_t chain [CORDIC_ITERATIONS+1];
  logic signed [OUTPUT_WIDTH-1:0] res [6];

  // stall the whole pipeline while a result waits
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv && scale_ready;
  assign cfg_ready = scale_ready;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign scale_start = cfg_wr && ((rtn_reg_t'(cfg_index) == REG_AXIS) ||
                                  (rtn_reg_t'(cfg_index) == REG_GM));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= AXIS_RESET;
      gm_r   <= GM_RESET;
      am_r   <= AXIS_MM_RESET;
      da_r   <= '0;
      dl_r   <= '0;
      ex_r   <= '0;
      ey_r   <= '0;
      ix_r   <= '0;
      iy_r   <= '0;
    end else if (cfg_wr) begin
      unique case (rtn_reg_t'(cfg_index))
        REG_AXIS: begin
          axis_r <= cfg_data[25:0];
          am_r   <= 36'(cfg_data[25:0]) * 36'd1000;
        end
        REG_GM: gm_r <= cfg_data;
        REG_DA: da_r <= cfg_data[31:0];
        REG_DL: dl_r <= cfg_data[31:0];
        REG_EX: ex_r <= cfg_data[31:0];
        REG_EY: ey_r <= cfg_data[31:0];
        REG_IX: ix_r <= cfg_data[31:0];
        REG_IY: iy_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  rtn_scale_unit u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scale_start),
    .axis  (axis_r),
    .gm    (gm_r),
    .ready (scale_ready),
    .vm    (vm)
  );

  rtn_angle_reduce u_reduce (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_tvalid && in_tready),
    .u      (in_tdata),
    .rot    (chain[0])
  );

  // rotation cells
  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
    rtn_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .stage_idx (IDX_W'(g)),
      .din       (chain[g]),
      .dout      (chain[g+1])
    );
  end

  rtn_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rot     (chain[CORDIC_ITERATIONS]),
    .da      (da_r),
    .dl      (dl_r),
    .ex      (ex_r),
    .ey      (ey_r),
    .ix      (ix_r),
    .iy      (iy_r),
    .am      (am_r),
    .vm      (vm),
    .out_vld (out_tvalid),
    .res     (res),
    .sat     (sat)
  );

  assign out_tdata = {res[5], res[4], res[3], res[2], res[1], res[0]};
  assign out_tuser = sat;

endmodule
